[hdl/lifo_free_list_slot_allocator_defines.svh]
// assertion helpers shared by the checker
`ifndef LIFO_FREE_LIST_SLOT_ALLOCATOR_DEFINES_SVH
`define LIFO_FREE_LIST_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LFSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LFSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lfsa_pkg.sv]
`default_nettype none

package lfsa_pkg;

  localparam int SLOTS    = 256;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int HANDLE_W = 16;
  localparam int CLASS_W  = 3;
  localparam int SLOT_W   = 9;
  localparam int STATUS_W = 3;
  localparam int ISTATE_W = 2;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_VACANT     = 3'd4;

  localparam logic [CLASS_W-1:0] CLASS_CLIENT  = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_AUTH    = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_RW      = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_TRACKER = 3'd3;

  localparam logic [ISTATE_W-1:0] IST_READING = 2'd0;
  localparam logic [ISTATE_W-1:0] IST_IDLE    = 2'd1;
  localparam logic [ISTATE_W-1:0] IST_LISTEN  = 2'd2;

  localparam logic [HANDLE_W-1:0] HANDLE_NONE = '1;

  // free stack update
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_slot;
  } stk_ctrl_t;

  // handle table update
  typedef struct packed {
    logic                attach;
    logic [IDX_W-1:0]    attach_slot;
    logic [HANDLE_W-1:0] attach_handle;
    logic                detach;
    logic [IDX_W-1:0]    detach_slot;
  } tbl_ctrl_t;

  function automatic logic [ISTATE_W-1:0] class_state(input logic [CLASS_W-1:0] cls);
    logic [ISTATE_W-1:0] st;
    case (cls)
      CLASS_CLIENT:  st = IST_READING;
      CLASS_AUTH:    st = IST_IDLE;
      CLASS_RW:      st = IST_IDLE;
      CLASS_TRACKER: st = IST_IDLE;
      default:       st = IST_LISTEN;
    endcase
    return st;
  endfunction

  // stack entry at a position never written since reset
  function automatic logic [IDX_W-1:0] init_entry(input logic [IDX_W-1:0] pos);
    return IDX_W'(SLOTS - 1) - pos;
  endfunction

endpackage

`default_nettype wire

[hdl/lfsa_free_stack.sv]
`default_nettype none

module lfsa_free_stack (
  input  logic                       clk,
  input  logic                       rst,
  input  lfsa_pkg::stk_ctrl_t        ctrl,
  output logic [lfsa_pkg::IDX_W-1:0] head,
  output logic                       empty
);
  import lfsa_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] low;
  logic [CNT_W-1:0] low_next;
  logic [IDX_W-1:0] top0;
  logic [IDX_W-1:0] top1;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_addr_next;
  logic             rd_init;
  logic             rd_init_next;
  logic [IDX_W-1:0] stk_q;
  logic [IDX_W-1:0] rd_data;
  logic [IDX_W-1:0] mem [SLOTS];

  // top two entries live in registers, the third is prefetched
  always_comb begin
    count_next = count;
    if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end else if (ctrl.push) begin
      count_next = count + CNT_W'(1);
    end
    low_next     = (count_next < low) ? count_next : low;
    rd_addr_next = IDX_W'(count_next - CNT_W'(3));
    rd_init_next = ({1'b0, count_next} < ({1'b0, low_next} + (CNT_W + 1)'(3)));
    rd_data      = rd_init ? init_entry(rd_addr) : stk_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= CNT_W'(SLOTS);
      low     <= CNT_W'(SLOTS);
      top0    <= init_entry(IDX_W'(SLOTS - 1));
      top1    <= init_entry(IDX_W'(SLOTS - 2));
      rd_addr <= IDX_W'(SLOTS - 3);
      rd_init <= 1'b1;
    end else begin
      count   <= count_next;
      low     <= low_next;
      rd_addr <= rd_addr_next;
      rd_init <= rd_init_next;
      if (ctrl.pop) begin
        top0 <= top1;
        top1 <= rd_data;
      end else if (ctrl.push) begin
        top1 <= top0;
        top0 <= ctrl.push_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[IDX_W-1:0]] <= ctrl.push_slot;
    end
    stk_q <= mem[rd_addr_next];
  end

  assign head  = top0;
  assign empty = (count == '0);

endmodule

`default_nettype wire

[hdl/lfsa_handle_table.sv]
`default_nettype none

module lfsa_handle_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [lfsa_pkg::IDX_W-1:0]    rd_slot,
  input  lfsa_pkg::tbl_ctrl_t           ctrl,
  input  logic [lfsa_pkg::IDX_W-1:0]    chk_slot,
  output logic                          occupied,
  output logic [lfsa_pkg::HANDLE_W-1:0] rd_handle
);
  import lfsa_pkg::*;

  logic [SLOTS-1:0]    occ;
  logic [HANDLE_W-1:0] mem [SLOTS];
  logic [HANDLE_W-1:0] mem_q;
  logic                fwd_hit;
  logic [HANDLE_W-1:0] fwd_data;

  // occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      if (ctrl.attach) begin
        occ[ctrl.attach_slot] <= 1'b1;
      end
      if (ctrl.detach) begin
        occ[ctrl.detach_slot] <= 1'b0;
      end
    end
  end

  // bound handles, read ahead when the word enters
  always_ff @(posedge clk) begin
    if (ctrl.attach) begin
      mem[ctrl.attach_slot] <= ctrl.attach_handle;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_slot];
      fwd_data <= ctrl.attach_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= ctrl.attach && (ctrl.attach_slot == rd_slot);
    end
  end

  assign rd_handle = fwd_hit ? fwd_data : mem_q;
  assign occupied  = occ[chk_slot];

endmodule

`default_nettype wire

[hdl/lifo_free_list_slot_allocator.sv]
`default_nettype none
// slot allocator with a last-in first-out free list
// input channel (in_valid / in_ready) carries one word per operation:
//   kind 0 allocates a slot and binds handle, conn_class picks the initial state
//   kind 1 releases slot_index and returns the bound handle for closing
// output channel (out_valid / out_ready) carries one result word per input word:
//   status, granted_slot, initial_state, released_handle
// path: an accepted word is decided in the input register and then moves into
//   the result register, which drives the output
// throughput: one word per cycle while out_ready is held; the head of the free list sits in registers
//   and the next free slot is prefetched from the stack memory every cycle
// reset: every slot vacant, free list holds all slots with slot 0 on top
//   (lowest index first); no memory clearing pass is needed
// receiver stall: the result word holds; one more word waits in the input
//   register, after which in_ready drops until out_ready returns

module lifo_free_list_slot_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [lfsa_pkg::HANDLE_W-1:0] handle,
  input  logic [lfsa_pkg::CLASS_W-1:0]         conn_class,
  input  logic [lfsa_pkg::SLOT_W-1:0]          slot_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lfsa_pkg::STATUS_W-1:0]        status,
  output logic [lfsa_pkg::IDX_W-1:0]           granted_slot,
  output logic [lfsa_pkg::ISTATE_W-1:0]        initial_state,
  output logic signed [lfsa_pkg::HANDLE_W-1:0] released_handle
);
  import lfsa_pkg::*;

  // input register
  logic                a_valid;
  logic                a_kind;
  logic [HANDLE_W-1:0] a_handle;
  logic [CLASS_W-1:0]  a_class;
  logic [SLOT_W-1:0]   a_slot;

  logic accept;
  logic advance;

  // decision
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_granted;
  logic [ISTATE_W-1:0] res_init;
  logic [HANDLE_W-1:0] res_released;
  logic                alloc_ok;
  logic                rel_ok;

  logic [IDX_W-1:0]    head;
  logic                empty;
  logic                occupied;
  logic [HANDLE_W-1:0] bound;

  stk_ctrl_t stk_ctrl;
  tbl_ctrl_t tbl_ctrl;

  assign advance  = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind   <= kind;
      a_handle <= HANDLE_W'(handle);
      a_class  <= conn_class;
      a_slot   <= slot_index;
    end
  end

  // empty pool wins over a bad handle; range wins over vacancy
  always_comb begin
    res_status   = ST_OK;
    res_granted  = '0;
    res_init     = IST_READING;
    res_released = HANDLE_NONE;
    alloc_ok     = 1'b0;
    rel_ok       = 1'b0;
    if (a_kind == KIND_ALLOC) begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else if (a_handle[HANDLE_W-1]) begin
        res_status = ST_BAD_HANDLE;
      end else begin
        alloc_ok    = 1'b1;
        res_granted = head;
        res_init    = class_state(a_class);
      end
    end else begin
      if (a_slot >= SLOT_W'(SLOTS)) begin
        res_status = ST_RANGE;
      end else if (!occupied) begin
        res_status = ST_VACANT;
      end else begin
        rel_ok       = 1'b1;
        res_released = bound;
      end
    end
  end

  always_comb begin
    stk_ctrl.pop           = advance && alloc_ok;
    stk_ctrl.push          = advance && rel_ok;
    stk_ctrl.push_slot     = a_slot[IDX_W-1:0];
    tbl_ctrl.attach        = advance && alloc_ok;
    tbl_ctrl.attach_slot   = head;
    tbl_ctrl.attach_handle = a_handle;
    tbl_ctrl.detach        = advance && rel_ok;
    tbl_ctrl.detach_slot   = a_slot[IDX_W-1:0];
  end

  lfsa_free_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (stk_ctrl),
    .head  (head),
    .empty (empty)
  );

  // handle lookup starts as the word enters, addressed straight from the port
  lfsa_handle_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_slot   (slot_index[IDX_W-1:0]),
    .ctrl      (tbl_ctrl),
    .chk_slot  (a_slot[IDX_W-1:0]),
    .occupied  (occupied),
    .rd_handle (bound)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status          <= res_status;
      granted_slot    <= res_granted;
      initial_state   <= res_init;
      released_handle <= $signed(res_released);
    end
  end

endmodule

`default_nettype wire

[hdl/lfsa_checker.sv]
`default_nettype none
`include "lifo_free_list_slot_allocator_defines.svh"

module lfsa_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [lfsa_pkg::STATUS_W-1:0]        status,
  input  logic [lfsa_pkg::IDX_W-1:0]           granted_slot,
  input  logic [lfsa_pkg::ISTATE_W-1:0]        initial_state,
  input  logic signed [lfsa_pkg::HANDLE_W-1:0] released_handle
);
  import lfsa_pkg::*;

  // a stalled result word holds
  `LFSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_slot) && $stable(initial_state) && $stable(released_handle), "result word changed while stalled")

  // failures carry no slot, no state and no handle
  `LFSA_ASSERT_SAME(a_fail_clean, out_valid && (status != ST_OK), (granted_slot == '0) && (initial_state == IST_READING) && (&released_handle), "failed result carries data")

  // a returned handle only comes from a successful release
  `LFSA_ASSERT_SAME(a_release_ok, out_valid && !(&released_handle), (status == ST_OK) && (granted_slot == '0) && !released_handle[HANDLE_W-1], "released handle on a bad result")

  // input only backs up behind a stalled output
  `LFSA_ASSERT_SAME(a_backpressure, !in_ready, out_valid && !out_ready, "input stalled without output stall")

endmodule

bind lifo_free_list_slot_allocator lfsa_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .granted_slot    (granted_slot),
  .initial_state   (initial_state),
  .released_handle (released_handle)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import lfsa_pkg::*;

  // one operation word and one reply word, at the block's port widths
  typedef struct packed {
    logic                       kind;
    logic signed [HANDLE_W-1:0] handle;
    logic [CLASS_W-1:0]         conn_class;
    logic [SLOT_W-1:0]          slot_index;
  } op_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [IDX_W-1:0]           granted_slot;
    logic [ISTATE_W-1:0]        initial_state;
    logic signed [HANDLE_W-1:0] released_handle;
  } reply_word_t;

  // directed row: reply typed in when fixed is set, else taken from the slot model
  typedef struct packed {
    op_word_t    op;
    logic        fixed;
    reply_word_t reply;
  } plan_row_t;

  localparam int          PLAN_ROWS   = 24;
  localparam int          RANDOM_OPS  = 1200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CLASS_W-1:0] CLASS_LISTENER = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_ANY      = 3'd7;

  localparam reply_word_t NO_REPLY   = '{ST_OK, '0, '0, HANDLE_NONE};
  localparam reply_word_t VACANT_REP = '{ST_VACANT, '0, '0, HANDLE_NONE};
  localparam reply_word_t RANGE_REP  = '{ST_RANGE, '0, '0, HANDLE_NONE};
  localparam reply_word_t BAD_REP    = '{ST_BAD_HANDLE, '0, '0, HANDLE_NONE};

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // releases straight after reset: nothing bound yet, then both range edges
    '{'{KIND_RELEASE, 16'sd0, CLASS_CLIENT, 9'd0},   1'b1, VACANT_REP},
    '{'{KIND_RELEASE, 16'sd0, CLASS_CLIENT, 9'd511}, 1'b1, RANGE_REP},
    '{'{KIND_RELEASE, 16'sd0, CLASS_CLIENT, 9'd256}, 1'b1, RANGE_REP},
    '{'{KIND_RELEASE, 16'sd0, CLASS_CLIENT, 9'd255}, 1'b1, VACANT_REP},
    // negative handles are refused and leave the list alone
    '{'{KIND_ALLOC, -16'sd1, CLASS_CLIENT, 9'd0},      1'b1, BAD_REP},
    '{'{KIND_ALLOC, -16'sd32768, CLASS_ANY, 9'd0},     1'b1, BAD_REP},
    // each named class code, slots handed out lowest first
    '{'{KIND_ALLOC, 16'sd0, CLASS_CLIENT, 9'd511},     1'b1,
      '{ST_OK, 8'd0, IST_READING, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sd32767, CLASS_AUTH, 9'h1ff},   1'b1,
      '{ST_OK, 8'd1, IST_IDLE, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sh5555, CLASS_RW, 9'd0},        1'b1,
      '{ST_OK, 8'd2, IST_IDLE, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sh2aaa, CLASS_TRACKER, 9'd0},   1'b1,
      '{ST_OK, 8'd3, IST_IDLE, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sd100, CLASS_LISTENER, 9'd0},   1'b1,
      '{ST_OK, 8'd4, IST_LISTEN, HANDLE_NONE}},
    // class codes past listener behave as listener
    '{'{KIND_ALLOC, 16'sd101, 3'd5, 9'd0},             1'b1,
      '{ST_OK, 8'd5, IST_LISTEN, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sd102, 3'd6, 9'd0},             1'b1,
      '{ST_OK, 8'd6, IST_LISTEN, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sd103, CLASS_ANY, 9'd0},        1'b1,
      '{ST_OK, 8'd7, IST_LISTEN, HANDLE_NONE}},
    // release ignores handle and class, a second release finds it vacant
    '{'{KIND_RELEASE, -16'sd1, CLASS_ANY, 9'd3},       1'b1,
      '{ST_OK, 8'd0, '0, 16'sh2aaa}},
    '{'{KIND_RELEASE, -16'sd1, CLASS_ANY, 9'd3},       1'b1, VACANT_REP},
    '{'{KIND_RELEASE, 16'sd9, CLASS_CLIENT, 9'd0},     1'b1,
      '{ST_OK, 8'd0, '0, 16'sd0}},
    // last released comes back first
    '{'{KIND_ALLOC, 16'sd200, CLASS_CLIENT, 9'd3},     1'b1,
      '{ST_OK, 8'd0, IST_READING, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sd201, CLASS_AUTH, 9'd0},       1'b1,
      '{ST_OK, 8'd3, IST_IDLE, HANDLE_NONE}},
    '{'{KIND_ALLOC, 16'sd202, CLASS_RW, 9'd0},         1'b0, NO_REPLY},
    '{'{KIND_RELEASE, 16'sh7fff, CLASS_RW, 9'd1},      1'b1,
      '{ST_OK, 8'd0, '0, 16'sd32767}},
    '{'{KIND_RELEASE, 16'sd0, CLASS_CLIENT, 9'd1},     1'b0, NO_REPLY},
    '{'{KIND_RELEASE, 16'sd0, CLASS_CLIENT, 9'd8},     1'b0, NO_REPLY},
    '{'{KIND_ALLOC, 16'sd203, CLASS_LISTENER, 9'd0},   1'b0, NO_REPLY}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       kind       = KIND_ALLOC;
  logic signed [HANDLE_W-1:0] handle     = '0;
  logic [CLASS_W-1:0]         conn_class = CLASS_CLIENT;
  logic [SLOT_W-1:0]          slot_index = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic [IDX_W-1:0]           granted_slot;
  logic [ISTATE_W-1:0]        initial_state;
  logic signed [HANDLE_W-1:0] released_handle;

  lifo_free_list_slot_allocator dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .handle          (handle),
    .conn_class      (conn_class),
    .slot_index      (slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_slot    (granted_slot),
    .initial_state   (initial_state),
    .released_handle (released_handle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slot model: free list head, links and bound handles
  logic [SLOT_W-1:0]          list_head;
  logic [SLOT_W-1:0]          list_link [SLOTS];
  logic signed [HANDLE_W-1:0] slot_owner [SLOTS];
  int                         busy_slots;

  reply_word_t  pending_replies [$];
  int unsigned  bad_replies = 0;
  int unsigned  cycle_count = 0;
  bit           calm = 1'b1;   // set: neither side idles

  function automatic reply_word_t model_slot_op(input op_word_t op);
    reply_word_t       r;
    logic [IDX_W-1:0]  pos;
    r = NO_REPLY;
    if (op.kind == KIND_ALLOC) begin
      pos = list_head[IDX_W-1:0];
      if (list_head >= SLOTS) begin
        r.status = ST_EMPTY;   // empty pool wins over a bad handle
      end else if (op.handle[HANDLE_W-1]) begin
        r.status = ST_BAD_HANDLE;
      end else begin
        r.granted_slot = pos;
        if (op.conn_class == CLASS_CLIENT)
          r.initial_state = IST_READING;
        else if (op.conn_class <= CLASS_TRACKER)
          r.initial_state = IST_IDLE;
        else
          r.initial_state = IST_LISTEN;
        slot_owner[pos] = op.handle;
        list_head = list_link[pos];
        busy_slots++;
      end
    end else begin
      pos = op.slot_index[IDX_W-1:0];
      if (op.slot_index >= SLOTS) begin
        r.status = ST_RANGE;
      end else if (slot_owner[pos] == HANDLE_NONE) begin
        r.status = ST_VACANT;
      end else begin
        r.released_handle = slot_owner[pos];
        slot_owner[pos] = HANDLE_NONE;
        list_link[pos] = list_head;
        list_head = op.slot_index;
        busy_slots--;
      end
    end
    return r;
  endfunction

  function automatic int idle_cycles();
    if (calm)
      return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 18);
  endfunction

  // random word: alloc share set by alloc_pct, releases mostly of bound slots, handles mostly good, some noise
  function automatic op_word_t random_op(input int alloc_pct);
    op_word_t op;
    int       start;
    op.handle     = $urandom_range(0, 32767);
    op.conn_class = $urandom_range(0, 7);
    op.slot_index = $urandom_range(0, 511);
    if ($urandom_range(1, 100) <= alloc_pct) begin
      op.kind = KIND_ALLOC;
      if ($urandom_range(0, 9) == 0)
        op.handle = $urandom_range(0, 3) == 0 ? -16'sd1 : {1'b1, 15'($urandom)};
    end else begin
      op.kind   = KIND_RELEASE;
      op.handle = 16'($urandom);
      if (busy_slots != 0 && $urandom_range(0, 9) != 0) begin
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_owner[(start + k) % SLOTS] != HANDLE_NONE) begin
            op.slot_index = SLOT_W'((start + k) % SLOTS);
            break;
          end
        end
      end
    end
    return op;
  endfunction

  // present one word, hold it until taken, then log its reply
  task automatic put_word(input op_word_t op, input logic fixed, input reply_word_t reply);
    int          gap;
    reply_word_t predicted;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= op.kind;
    handle     <= op.handle;
    conn_class <= op.conn_class;
    slot_index <= op.slot_index;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = model_slot_op(op);
    pending_replies.push_back(fixed ? reply : predicted);
  endtask

  initial begin : stimulus
    int sent;
    int alloc_pct;
    int burst;
    for (int i = 0; i < SLOTS; i++) begin
      list_link[i]  = SLOT_W'(i + 1);
      slot_owner[i] = HANDLE_NONE;
    end
    list_head  = '0;
    busy_slots = 0;
    sent       = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed words back to back
    for (int i = 0; i < PLAN_ROWS; i++)
      put_word(PLAN[i].op, PLAN[i].fixed, PLAN[i].reply);

    // random bursts: fill the pool first, then mix fill, drain and churn
    for (int round = 0; sent < RANDOM_OPS; round++) begin
      case (round == 0 ? 0 : $urandom_range(0, 3))
        0:       alloc_pct = 95;
        1:       alloc_pct = 10;
        default: alloc_pct = 50;
      endcase
      burst = round == 0 ? 320 : $urandom_range(40, 200);
      if (burst > RANDOM_OPS - sent)
        burst = RANDOM_OPS - sent;
      calm  = $urandom_range(0, 3) == 0;
      repeat (burst) put_word(random_op(alloc_pct), 1'b0, NO_REPLY);
      sent += burst;
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_replies == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // reply side: random stalls, every word taken is checked in order
  initial begin : reply_sink
    int          stall;
    reply_word_t got;
    reply_word_t want;
    wait (rst == 1'b0);
    forever begin
      stall = idle_cycles();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got = '{status, granted_slot, initial_state, released_handle};
      if (pending_replies.size() == 0) begin
        if (bad_replies < 10)
          $display("unexpected reply word: status %0d slot %0d state %0d handle %0d",
                   got.status, got.granted_slot, got.initial_state, got.released_handle);
        bad_replies++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.granted_slot !== want.granted_slot ||
            got.initial_state !== want.initial_state ||
            got.released_handle !== want.released_handle) begin
          if (bad_replies < 10)
            $display("reply mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.granted_slot, want.initial_state, want.released_handle,
                     got.status, got.granted_slot, got.initial_state, got.released_handle);
          bad_replies++;
        end
      end
    end
  end

  // hang guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
